FILE: rtl/assert_macros.svh
// Assertion macros used by matrix4_inverse_core, the RTL file that carries checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

FILE: rtl/mi4_pkg.sv
// Shared types, constants and index functions of the 4x4 matrix inverse core.
package mi4_pkg;

    localparam int DataWidthDef = 32;
    localparam int FracBitsDef  = 16;
    localparam int EpsWidth     = 31;
    localparam int LimbBits     = 16;
    localparam int IdxWidth     = 4;
    localparam int NumEl        = 16;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD_EL,
        OP_LOAD_A,
        OP_MUL,
        OP_T_TO_A,
        OP_ACC_ADD,
        OP_ADJ_WR,
        OP_ADJ_TO_A,
        OP_DET_WR,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_FIN,
        OP_OUT_SING
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [IdxWidth-1:0] sel;
        logic                neg;
    } t_cmd;

    typedef struct packed {
        logic singular;
        logic out_last;
    } t_status;

    typedef enum logic [3:0] {
        S_LOAD,
        S_TERM_A,
        S_MUL1,
        S_MOVE,
        S_MUL2,
        S_ACC,
        S_ADJ,
        S_DET_A,
        S_DMUL,
        S_DACC,
        S_DET_WR,
        S_CHECK,
        S_DIV_INIT,
        S_DIV,
        S_DIV_FIN,
        S_OUT
    } t_state;

    // Internal word width, a whole number of limbs that holds the determinant and
    // the scaled adjugate numerator.
    function automatic int wide_width(input int dw, input int fb);
        int a;
        int b;
        int m;
        a = 4 * dw + 8;
        b = 3 * dw + 2 * fb + 8;
        m = (a > b) ? a : b;
        return ((m + LimbBits - 1) / LimbBits) * LimbBits;
    endfunction

    function automatic logic [1:0] skip_one(input logic [1:0] excl, input logic [1:0] n);
        return (n < excl) ? n : 2'(n + 2'd1);
    endfunction

    function automatic logic [1:0] perm3(input logic [2:0] term, input logic [1:0] slot);
        logic [5:0] p;
        case (term)
            3'd0: p = {2'd2, 2'd1, 2'd0};
            3'd1: p = {2'd1, 2'd2, 2'd0};
            3'd2: p = {2'd2, 2'd0, 2'd1};
            3'd3: p = {2'd0, 2'd2, 2'd1};
            3'd4: p = {2'd1, 2'd0, 2'd2};
            default: p = {2'd0, 2'd1, 2'd2};
        endcase
        return p[slot*2 +: 2];
    endfunction

    // Element feeding factor slot of permutation term for adjugate entry k.
    function automatic logic [IdxWidth-1:0] cof_sel(input logic [IdxWidth-1:0] k,
                                                    input logic [2:0] term,
                                                    input logic [1:0] slot);
        logic [1:0] r;
        logic [1:0] c;
        r = skip_one(k[1:0], slot);
        c = skip_one(k[3:2], perm3(term, slot));
        return {r, c};
    endfunction

    function automatic logic cof_neg(input logic [IdxWidth-1:0] k, input logic [2:0] term);
        logic odd_perm;
        odd_perm = (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
        return odd_perm ^ k[2] ^ k[0];
    endfunction

endpackage

FILE: rtl/mi4_datapath.sv
// Datapath: element store, limb-serial multiplier, accumulators and bit-serial divider.
module mi4_datapath
    import mi4_pkg::*;
#(
    parameter int DATA_WIDTH = DataWidthDef,
    parameter int FRAC_BITS  = FracBitsDef
) (
    input  logic                  i_clk,
    input  t_cmd                  i_cmd,
    input  logic [DATA_WIDTH-1:0] i_el,
    input  logic [EpsWidth-1:0]   i_eps,
    output t_status               o_status,
    output logic [DATA_WIDTH-1:0] o_value,
    output logic [IdxWidth-1:0]   o_index,
    output logic                  o_singular,
    output logic                  o_saturated
);

    localparam int WW = wide_width(DATA_WIDTH, FRAC_BITS);
    localparam int PW = LimbBits + DATA_WIDTH + 1;

    logic [DATA_WIDTH-1:0] r_el [NumEl];
    logic [WW-1:0]         r_adj [NumEl];
    logic [WW-1:0]         r_a, r_t, r_acc, r_dmag, r_num, r_rem, r_q;
    logic                  r_dneg, r_aneg;
    logic [DATA_WIDTH-1:0] r_value;
    logic [IdxWidth-1:0]   r_index;
    logic                  r_singular, r_saturated, r_last;

    logic signed [DATA_WIDTH-1:0] el_sel;
    logic signed [PW-1:0]         prod;
    logic [WW-1:0]                prod_ext, el_ext, adj_sel, adj_mag, acc_mag, eps_ext;
    logic [WW:0]                  step_r2, fin_r2, dmag_ext, q_fin, lim;
    logic                         step_ge, fin_ge, neg_fin, sat_fin;
    logic [DATA_WIDTH-1:0]        val_fin;

    assign el_sel   = r_el[i_cmd.sel];
    assign el_ext   = {{(WW-DATA_WIDTH){el_sel[DATA_WIDTH-1]}}, el_sel};
    assign prod     = $signed({1'b0, r_a[WW-1 -: LimbBits]}) * el_sel;
    assign prod_ext = {{(WW-PW){prod[PW-1]}}, prod};
    assign adj_sel  = r_adj[i_cmd.sel];
    assign adj_mag  = adj_sel[WW-1] ? (~adj_sel + 1'b1) : adj_sel;
    assign acc_mag  = r_acc[WW-1] ? (~r_acc + 1'b1) : r_acc;
    assign eps_ext  = {{(WW-EpsWidth-3*FRAC_BITS){1'b0}}, i_eps, {(3*FRAC_BITS){1'b0}}};
    assign dmag_ext = {1'b0, r_dmag};

    assign step_r2 = {r_rem, r_num[WW-1]};
    assign step_ge = step_r2 >= dmag_ext;
    assign fin_r2  = {r_rem, 1'b0};
    assign fin_ge  = fin_r2 >= dmag_ext;
    assign q_fin   = {1'b0, r_q} + {{WW{1'b0}}, fin_ge};
    assign neg_fin = (r_aneg ^ r_dneg) && (q_fin != '0);
    assign lim     = neg_fin ? ((WW+1)'(1) << (DATA_WIDTH-1))
                             : (((WW+1)'(1) << (DATA_WIDTH-1)) - 1'b1);
    assign sat_fin = q_fin > lim;

    always_comb begin
        if (sat_fin) begin
            val_fin = neg_fin ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : {1'b0, {(DATA_WIDTH-1){1'b1}}};
        end else if (neg_fin) begin
            val_fin = ~q_fin[DATA_WIDTH-1:0] + 1'b1;
        end else begin
            val_fin = q_fin[DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_LOAD_EL: begin
                r_el[i_cmd.sel] <= i_el;
                r_acc           <= '0;
            end
            OP_LOAD_A: begin
                r_a <= el_ext;
                r_t <= '0;
            end
            OP_MUL: begin
                r_t <= {r_t[WW-LimbBits-1:0], {LimbBits{1'b0}}} + prod_ext;
                r_a <= {r_a[WW-LimbBits-1:0], {LimbBits{1'b0}}};
            end
            OP_T_TO_A: begin
                r_a <= r_t;
                r_t <= '0;
            end
            OP_ACC_ADD: begin
                r_acc <= i_cmd.neg ? (r_acc - r_t) : (r_acc + r_t);
            end
            OP_ADJ_WR: begin
                r_adj[i_cmd.sel] <= r_acc;
                r_acc            <= '0;
            end
            OP_ADJ_TO_A: begin
                r_a <= adj_sel;
                r_t <= '0;
            end
            OP_DET_WR: begin
                r_dmag <= acc_mag;
                r_dneg <= r_acc[WW-1];
                r_acc  <= '0;
            end
            OP_DIV_INIT: begin
                r_num  <= adj_mag << (2*FRAC_BITS);
                r_aneg <= adj_sel[WW-1];
                r_rem  <= '0;
                r_q    <= '0;
            end
            OP_DIV_STEP: begin
                r_rem <= step_ge ? WW'(step_r2 - dmag_ext) : step_r2[WW-1:0];
                r_q   <= {r_q[WW-2:0], step_ge};
                r_num <= {r_num[WW-2:0], 1'b0};
            end
            OP_DIV_FIN: begin
                r_value     <= val_fin;
                r_index     <= i_cmd.sel;
                r_singular  <= 1'b0;
                r_saturated <= sat_fin;
                r_last      <= &i_cmd.sel;
            end
            OP_OUT_SING: begin
                r_value     <= '0;
                r_index     <= '0;
                r_singular  <= 1'b1;
                r_saturated <= 1'b0;
                r_last      <= 1'b1;
            end
            default: begin
            end
        endcase
    end

    assign o_status.singular = (r_dmag == '0) || (r_dmag < eps_ext);
    assign o_status.out_last = r_last;
    assign o_value           = r_value;
    assign o_index           = r_index;
    assign o_singular        = r_singular;
    assign o_saturated       = r_saturated;

endmodule

FILE: rtl/mi4_ctrl.sv
// Controller: sequences loading, cofactor terms, determinant, division and output.
module mi4_ctrl
    import mi4_pkg::*;
#(
    parameter int DATA_WIDTH = DataWidthDef,
    parameter int FRAC_BITS  = FracBitsDef
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    localparam int WW = wide_width(DATA_WIDTH, FRAC_BITS);
    localparam int NL = WW / LimbBits;
    localparam int CW = $clog2(WW);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [IdxWidth-1:0] r_k, n_k, r_load, n_load;
    logic [2:0]          r_term, n_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_cnt   <= '0;
            r_k     <= '0;
            r_load  <= '0;
            r_term  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_load  <= n_load;
            r_term  <= n_term;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_load      = r_load;
        n_term      = r_term;
        o_cmd.op    = OP_NONE;
        o_cmd.sel   = r_k;
        o_cmd.neg   = 1'b0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.sel  = r_load;
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD_EL;
                    n_load   = r_load + 1'b1;
                    if (&r_load) begin
                        n_state = S_TERM_A;
                        n_k     = '0;
                        n_term  = '0;
                    end
                end
            end
            S_TERM_A: begin
                o_cmd.op  = OP_LOAD_A;
                o_cmd.sel = cof_sel(r_k, r_term, 2'd0);
                n_cnt     = '0;
                n_state   = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.op  = OP_MUL;
                o_cmd.sel = cof_sel(r_k, r_term, 2'd1);
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CW'(NL-1)) begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                o_cmd.op = OP_T_TO_A;
                n_cnt    = '0;
                n_state  = S_MUL2;
            end
            S_MUL2: begin
                o_cmd.op  = OP_MUL;
                o_cmd.sel = cof_sel(r_k, r_term, 2'd2);
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == CW'(NL-1)) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: begin
                o_cmd.op  = OP_ACC_ADD;
                o_cmd.neg = cof_neg(r_k, r_term);
                if (r_term == 3'd5) begin
                    n_term  = '0;
                    n_state = S_ADJ;
                end else begin
                    n_term  = r_term + 1'b1;
                    n_state = S_TERM_A;
                end
            end
            S_ADJ: begin
                o_cmd.op = OP_ADJ_WR;
                n_k      = r_k + 1'b1;
                n_state  = (&r_k) ? S_DET_A : S_TERM_A;
            end
            S_DET_A: begin
                o_cmd.op  = OP_ADJ_TO_A;
                o_cmd.sel = {r_k[1:0], 2'b00};
                n_cnt     = '0;
                n_state   = S_DMUL;
            end
            S_DMUL: begin
                o_cmd.op = OP_MUL;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CW'(NL-1)) begin
                    n_state = S_DACC;
                end
            end
            S_DACC: begin
                o_cmd.op = OP_ACC_ADD;
                if (r_k == IdxWidth'(3)) begin
                    n_k     = '0;
                    n_state = S_DET_WR;
                end else begin
                    n_k     = r_k + 1'b1;
                    n_state = S_DET_A;
                end
            end
            S_DET_WR: begin
                o_cmd.op = OP_DET_WR;
                n_state  = S_CHECK;
            end
            S_CHECK: begin
                n_k = '0;
                if (i_status.singular) begin
                    o_cmd.op = OP_OUT_SING;
                    n_state  = S_OUT;
                end else begin
                    n_state = S_DIV_INIT;
                end
            end
            S_DIV_INIT: begin
                o_cmd.op = OP_DIV_INIT;
                n_cnt    = '0;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = OP_DIV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == CW'(WW-1)) begin
                    n_state = S_DIV_FIN;
                end
            end
            S_DIV_FIN: begin
                o_cmd.op = OP_DIV_FIN;
                n_state  = S_OUT;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_status.out_last) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = S_DIV_INIT;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

endmodule

FILE: rtl/matrix4_inverse_core.sv
// The core takes 16 elements, one per cycle while s_axis_tvalid is high, then forms the
// cofactor terms and determinant (NL = internal width / 16 limbs, 9 at the defaults).
// Each of the 16 results is divided bit-serially and held until m_axis_tready takes it;
// a zero or sub-epsilon determinant gives one singular result. Work is paced by the
// 16-bit limb multiplier and one-bit-per-cycle divider. Synchronous active-low reset
// clears controller and load count, sets epsilon_threshold to 1; element store is kept.
`include "assert_macros.svh"
module matrix4_inverse_core
    import mi4_pkg::*;
#(
    parameter int DATA_WIDTH = DataWidthDef,
    parameter int FRAC_BITS  = FracBitsDef
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // Fields from bit 0: element_value.
    input  logic [((DATA_WIDTH+7)/8)*8-1:0]       s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // Fields from bit 0: inverse_value, element_index.
    output logic [((DATA_WIDTH+IdxWidth+7)/8)*8-1:0] m_axis_tdata,
    // Fields from bit 0: singular, saturated.
    output logic [1:0]                            m_axis_tuser,
    output logic                                  m_axis_tlast,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [2:0]                            paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int OBW = ((DATA_WIDTH+IdxWidth+7)/8)*8;

    logic [EpsWidth-1:0]   r_eps;
    t_cmd                  cmd;
    t_status               status;
    logic [DATA_WIDTH-1:0] value;
    logic [IdxWidth-1:0]   index;
    logic                  singular, saturated;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {1'b0, r_eps};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EpsWidth'(1);
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_eps <= pwdata[EpsWidth-1:0];
        end
    end

    mi4_ctrl #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .o_out_valid(m_axis_tvalid),
        .i_out_ready(m_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    mi4_datapath #(
        .DATA_WIDTH(DATA_WIDTH),
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_cmd      (cmd),
        .i_el       (s_axis_tdata[DATA_WIDTH-1:0]),
        .i_eps      (r_eps),
        .o_status   (status),
        .o_value    (value),
        .o_index    (index),
        .o_singular (singular),
        .o_saturated(saturated)
    );

    assign m_axis_tdata = {{(OBW-DATA_WIDTH-IdxWidth){1'b0}}, index, value};
    assign m_axis_tuser = {saturated, singular};
    assign m_axis_tlast = status.out_last;

    `ASSERT_IMPLIES(a_one_side_busy, i_clk, i_rst_n, s_axis_tready, !m_axis_tvalid)
    `ASSERT_IMPLIES(a_singular_is_last, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser[0],
        m_axis_tlast && !m_axis_tuser[1])
    `ASSERT_NEXT(a_reload_after_last, i_clk, i_rst_n,
        m_axis_tvalid && m_axis_tready && m_axis_tlast, s_axis_tready)

endmodule
